### sv/gate_level_flow_pi_controller_unit_macros.svh
// ----------------------------------------------------------------------------
// Gate level / flow PI controller assertion macros
// Shared concurrent assertion forms for the controller checker.
// ----------------------------------------------------------------------------
`ifndef GATE_LEVEL_FLOW_PI_CONTROLLER_UNIT_MACROS_SVH
`define GATE_LEVEL_FLOW_PI_CONTROLLER_UNIT_MACROS_SVH

// Same-cycle implication, off during reset.
`define GLFPI_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off during reset.
`define GLFPI_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Checks the cycle right after reset.
`define GLFPI_ASSERT_RST(lbl, clk, rst, cons, msg) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error(msg);

`endif

### sv/glfpi_pkg.sv
// ----------------------------------------------------------------------------
// Gate level / flow PI controller package
// Action and mode codes, register indexes and loop gains.
// ----------------------------------------------------------------------------
package glfpi_pkg;

   typedef enum logic [2:0] {
      ACT_HOLD = 3'd0,
      ACT_STOP = 3'd1,
      ACT_UP   = 3'd2,
      ACT_DOWN = 3'd3,
      ACT_RUN  = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      MODE_SPEED = 2'd0,
      MODE_LEVEL = 2'd1,
      MODE_FLOW  = 2'd2
   } mode_type;

   typedef enum logic {
      OP_TICK  = 1'b0,
      OP_CLEAR = 1'b1
   } opcode_type;

   localparam logic [2:0] CSR_MODE           = 3'd0;
   localparam logic [2:0] CSR_LEVEL_SETPOINT = 3'd1;
   localparam logic [2:0] CSR_FLOW_SETPOINT  = 3'd2;
   localparam logic [2:0] CSR_SPEED_LIMIT    = 3'd3;
   localparam logic [2:0] CSR_LEVEL_DEADBAND = 3'd4;
   localparam logic [2:0] CSR_FLOW_DEADBAND  = 3'd5;

   localparam logic [15:0] SPEED_LIMIT_RESET = 16'd1000;
   localparam logic [15:0] DEADBAND_RESET    = 16'd655;

   // Proportional gains (signed, for the 17 x 12 product)
   localparam logic signed [11:0] GAIN_LEVEL = 12'sd1500;
   localparam logic signed [11:0] GAIN_FLOW  = 12'sd100;

   // Stop threshold on the mode-0 speed magnitude
   localparam logic signed [16:0] SPEED_STOP = 17'sd10;

endpackage

### sv/gate_level_flow_pi_controller_unit.sv
// ----------------------------------------------------------------------------
// Gate level / flow PI controller
// One control tick per request: level-to-speed, level PI-to-opening or
// flow P-to-opening, with output clamps, deadband and limit-switch gating.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake           | payload
//   --------+-----+---------------------+----------------------------------------
//   req     | in  | req_valid/req_stall | opcode, level, flow, opening, switches
//   rsp     | out | rsp_valid/rsp_stall | action, drive speed, target, error
//   csr     | in  | csr_write           | csr_index, csr_wdata (16 bits)
//
// Four register stages (input, error/integral, clamp, action/output); one
// transfer per cycle sustained while rsp_stall is low; requests pass them in order.
// The integral moves as a request leaves the input stage, so back-to-back
// ticks see each other's sums without a bubble.
// Reset (synchronous) empties the pipe, zeroes the integral and loads the
// register defaults. A stalled response holds its stage; req_stall rises
// only once every stage behind it is full.
// ----------------------------------------------------------------------------
module gate_level_flow_pi_controller_unit #(
   parameter int INTEGRAL_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   // request
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_opcode,
   input  logic signed [15:0]     req_measured_level,
   input  logic signed [15:0]     req_measured_flow,
   input  logic [15:0]            req_gate_opening,
   input  logic                   req_upper_limit_hit,
   input  logic                   req_lower_limit_hit,
   // response
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output glfpi_pkg::action_type  rsp_action,
   output logic signed [16:0]     rsp_drive_speed,
   output logic [15:0]            rsp_target_opening,
   output logic signed [16:0]     rsp_control_error,
   // configuration
   input  logic                   csr_write,
   input  logic [2:0]             csr_index,
   input  logic [15:0]            csr_wdata
);
   import glfpi_pkg::*;

   localparam int IW = INTEGRAL_WIDTH;
   // Width of the product: 17-bit error times 12-bit gain
   localparam int PW = 29;
   // sum * 10 needs four more bits than the sum
   localparam int SW = IW + 4;
   // Controller output before clamping; one guard bit over the wider term
   localparam int VW = ((SW > PW) ? SW : PW) + 1;

   // ---------------- configuration registers ----------------
   mode_type           mode_ff;
   logic signed [15:0] level_setpoint_ff;
   logic signed [15:0] flow_setpoint_ff;
   logic [15:0]        speed_limit_ff;
   logic [15:0]        level_deadband_ff;
   logic [15:0]        flow_deadband_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= MODE_LEVEL;
         level_setpoint_ff <= '0;
         flow_setpoint_ff  <= '0;
         speed_limit_ff    <= SPEED_LIMIT_RESET;
         level_deadband_ff <= DEADBAND_RESET;
         flow_deadband_ff  <= DEADBAND_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_MODE:           mode_ff           <= mode_type'(csr_wdata[1:0]);
            CSR_LEVEL_SETPOINT: level_setpoint_ff <= csr_wdata;
            CSR_FLOW_SETPOINT:  flow_setpoint_ff  <= csr_wdata;
            CSR_SPEED_LIMIT:    speed_limit_ff    <= csr_wdata;
            CSR_LEVEL_DEADBAND: level_deadband_ff <= csr_wdata;
            CSR_FLOW_DEADBAND:  flow_deadband_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // ---------------- pipeline flow control ----------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic adv1, adv2, adv3, adv4;

   // A stage may load when it is empty or its content moves on this cycle
   assign adv4 = !s4_valid_ff || !rsp_stall;
   assign adv3 = !s3_valid_ff || adv4;
   assign adv2 = !s2_valid_ff || adv3;
   assign adv1 = !s1_valid_ff || adv2;

   assign req_stall = !adv1;
   assign rsp_valid = s4_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (adv1) s1_valid_ff <= req_valid;
         if (adv2) s2_valid_ff <= s1_valid_ff;
         if (adv3) s3_valid_ff <= s2_valid_ff;
         if (adv4) s4_valid_ff <= s3_valid_ff;
      end
   end

   // ---------------- stage 1: input register ----------------
   opcode_type         s1_opcode_ff;
   logic signed [15:0] s1_level_ff;
   logic signed [15:0] s1_flow_ff;
   logic [15:0]        s1_opening_ff;
   logic               s1_up_ff, s1_dn_ff;

   always_ff @(posedge clock) begin
      if (adv1 && req_valid) begin
         s1_opcode_ff  <= opcode_type'(req_opcode);
         s1_level_ff   <= req_measured_level;
         s1_flow_ff    <= req_measured_flow;
         s1_opening_ff <= req_gate_opening;
         s1_up_ff      <= req_upper_limit_hit;
         s1_dn_ff      <= req_lower_limit_hit;
      end
   end

   // ---------------- stage 2: error, gain product, integral ----------------
   logic signed [16:0]   err_level, err_flow, err_in;
   logic                 live_in;
   logic signed [11:0]   gain;
   logic signed [PW-1:0] prod_in;
   logic signed [IW-1:0] error_sum_ff, error_sum_in;
   logic signed [IW:0]   sum_wide;
   logic                 sum_upd;

   assign err_level = {level_setpoint_ff[15], level_setpoint_ff}
                    - {s1_level_ff[15], s1_level_ff};
   assign err_flow  = {flow_setpoint_ff[15], flow_setpoint_ff}
                    - {s1_flow_ff[15], s1_flow_ff};

   always_comb begin
      live_in = 1'b0;
      err_in  = '0;
      gain    = GAIN_LEVEL;
      if (s1_opcode_ff == OP_TICK) begin
         case (mode_ff)
            MODE_SPEED, MODE_LEVEL: begin
               live_in = 1'b1;
               err_in  = err_level;
            end
            MODE_FLOW: begin
               live_in = 1'b1;
               err_in  = err_flow;
               gain    = GAIN_FLOW;
            end
            default: begin
               // unused mode: hold with zero fields
            end
         endcase
      end
   end

   assign prod_in = err_in * gain;

   // Saturating accumulate of the level error
   assign sum_wide = {error_sum_ff[IW-1], error_sum_ff}
                   + {{(IW + 1 - 17){err_in[16]}}, err_in};

   always_comb begin
      if (s1_opcode_ff == OP_CLEAR) begin
         error_sum_in = '0;
      end else if (mode_ff == MODE_LEVEL) begin
         if (sum_wide[IW] != sum_wide[IW-1]) begin
            error_sum_in = sum_wide[IW] ? {1'b1, {(IW-1){1'b0}}}
                                        : {1'b0, {(IW-1){1'b1}}};
         end else begin
            error_sum_in = sum_wide[IW-1:0];
         end
      end else begin
         error_sum_in = error_sum_ff;
      end
   end

   // The integral moves exactly once, as the item leaves stage 1
   assign sum_upd = s1_valid_ff && adv2;

   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff <= '0;
      end else if (sum_upd) begin
         error_sum_ff <= error_sum_in;
      end
   end

   mode_type             s2_mode_ff;
   logic                 s2_live_ff;
   logic signed [16:0]   s2_err_ff;
   logic signed [PW-1:0] s2_prod_ff;
   logic signed [IW-1:0] s2_sum_ff;
   logic [15:0]          s2_opening_ff;
   logic                 s2_up_ff, s2_dn_ff;

   always_ff @(posedge clock) begin
      if (adv2 && s1_valid_ff) begin
         s2_mode_ff    <= mode_ff;
         s2_live_ff    <= live_in;
         s2_err_ff     <= err_in;
         s2_prod_ff    <= prod_in;
         s2_sum_ff     <= error_sum_in;
         s2_opening_ff <= s1_opening_ff;
         s2_up_ff      <= s1_up_ff;
         s2_dn_ff      <= s1_dn_ff;
      end
   end

   // ---------------- stage 3: controller output and clamps ----------------
   logic signed [SW-1:0] sum_ext;
   logic signed [VW-1:0] sum10, prod_ext, ctl_v;
   logic [15:0]          target_in;
   logic signed [20:0]   speed_raw, speed_lim;
   logic signed [16:0]   speed_in;

   assign sum_ext  = {{4{s2_sum_ff[IW-1]}}, s2_sum_ff};
   assign sum10    = {{(VW-SW){sum_ext[SW-1]}}, (sum_ext <<< 3) + (sum_ext <<< 1)};
   assign prod_ext = {{(VW-PW){s2_prod_ff[PW-1]}}, s2_prod_ff};
   assign ctl_v    = (s2_mode_ff == MODE_LEVEL) ? (prod_ext + sum10) : prod_ext;

   // Q8.8 output to Q0.16 target, clamped to [0, 1)
   always_comb begin
      if (ctl_v[VW-1] || (ctl_v == '0)) begin
         target_in = '0;
      end else if (|ctl_v[VW-2:8]) begin
         target_in = 16'hFFFF;
      end else begin
         target_in = {ctl_v[7:0], 8'h00};
      end
   end

   // Floor of product / 256, clamped to +-speed_limit
   assign speed_raw = s2_prod_ff[PW-1:8];
   assign speed_lim = {5'b0, speed_limit_ff};

   always_comb begin
      if (speed_raw > speed_lim) begin
         speed_in = speed_lim[16:0];
      end else if (speed_raw < -speed_lim) begin
         speed_in = -speed_lim[16:0];
      end else begin
         speed_in = speed_raw[16:0];
      end
   end

   mode_type           s3_mode_ff;
   logic               s3_live_ff;
   logic signed [16:0] s3_err_ff;
   logic signed [16:0] s3_speed_ff;
   logic [15:0]        s3_target_ff;
   logic [15:0]        s3_opening_ff;
   logic               s3_up_ff, s3_dn_ff;

   always_ff @(posedge clock) begin
      if (adv3 && s2_valid_ff) begin
         s3_mode_ff    <= s2_mode_ff;
         s3_live_ff    <= s2_live_ff;
         s3_err_ff     <= s2_err_ff;
         s3_speed_ff   <= speed_in;
         s3_target_ff  <= target_in;
         s3_opening_ff <= s2_opening_ff;
         s3_up_ff      <= s2_up_ff;
         s3_dn_ff      <= s2_dn_ff;
      end
   end

   // ---------------- stage 4: action decision and output register ----------
   logic signed [16:0] gap, gap_mag;
   logic [15:0]        band;
   action_type         action_in;
   logic signed [16:0] drive_in;
   logic [15:0]        target_out_in;

   assign gap     = {1'b0, s3_target_ff} - {1'b0, s3_opening_ff};
   assign gap_mag = gap[16] ? -gap : gap;
   assign band    = (s3_mode_ff == MODE_LEVEL) ? level_deadband_ff : flow_deadband_ff;

   always_comb begin
      action_in     = ACT_HOLD;
      drive_in      = '0;
      target_out_in = '0;
      if (s3_live_ff) begin
         case (s3_mode_ff)
            MODE_SPEED: begin
               drive_in = s3_speed_ff;
               if ((s3_speed_ff < SPEED_STOP) && (s3_speed_ff > -SPEED_STOP)) begin
                  action_in = ACT_STOP;
               end else if (!s3_speed_ff[16] && !s3_up_ff) begin
                  action_in = ACT_RUN;
               end else if (s3_speed_ff[16] && !s3_dn_ff) begin
                  action_in = ACT_RUN;
               end
            end
            MODE_LEVEL, MODE_FLOW: begin
               target_out_in = s3_target_ff;
               if (gap_mag < $signed({1'b0, band})) begin
                  action_in = ACT_STOP;
               end else if (!gap[16] && (gap != '0) && !s3_up_ff) begin
                  action_in = ACT_UP;
               end else if (gap[16] && !s3_dn_ff) begin
                  action_in = ACT_DOWN;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (adv4 && s3_valid_ff) begin
         rsp_action         <= action_in;
         rsp_drive_speed    <= drive_in;
         rsp_target_opening <= target_out_in;
         rsp_control_error  <= s3_err_ff;
      end
   end

endmodule

### sv/glfpi_checker.sv
// ----------------------------------------------------------------------------
// Gate level / flow PI controller checker
// Port-level assertions on response content and handshake, bound to the top.
// ----------------------------------------------------------------------------
`include "gate_level_flow_pi_controller_unit_macros.svh"

module glfpi_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [2:0]         rsp_action,
   input logic signed [16:0] rsp_drive_speed,
   input logic [15:0]        rsp_target_opening
);
   import glfpi_pkg::*;

   // Pipe is empty right after reset
   `GLFPI_ASSERT_RST(a_empty_after_reset, clock, reset, !rsp_valid, "response after reset")

   // A stalled response keeps its content
   `GLFPI_ASSERT_NXT(a_stall_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_action) && $stable(rsp_drive_speed) && $stable(rsp_target_opening), "stalled response changed")

   // Speed mode never reports a target; gate moves never report a speed
   `GLFPI_ASSERT_IMP(a_run_no_target, clock, reset, rsp_valid && (rsp_action == ACT_RUN), rsp_target_opening == 16'd0, "run with target")
   `GLFPI_ASSERT_IMP(a_move_no_speed, clock, reset, rsp_valid && ((rsp_action == ACT_UP) || (rsp_action == ACT_DOWN)), rsp_drive_speed == 17'sd0, "gate move with speed")

endmodule

bind gate_level_flow_pi_controller_unit glfpi_checker u_glfpi_checker (.*);

### verif/gate_level_flow_pi_controller_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gate level / flow PI controller testbench
// Runs control ticks and clear requests through the controller in all modes,
// predicts each response with an independent model of the control law and
// the integral, and compares every field. Register settings change between
// phases once the pipe has drained. Sender gaps and response stalls are random.
// ----------------------------------------------------------------------------
module gate_level_flow_pi_controller_unit_tb;
   import glfpi_pkg::*;

   // A narrow integral, so saturation is reachable in a few ticks
   localparam int     SUM_WIDTH = 20;
   localparam longint SUM_MAX   = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
   localparam longint SUM_MIN   = -SUM_MAX - 1;

   // Control law constants
   localparam longint LEVEL_GAIN = 1500;
   localparam longint SUM_GAIN   = 10;
   localparam longint FLOW_GAIN  = 100;
   localparam longint STOP_SPEED = 10;

   localparam int RANDOM_PHASES   = 10;
   localparam int ITEMS_PER_PHASE = 83;
   localparam int HOLD_PHASE      = 3;    // phase with the long receiver hold-off
   localparam int QUIET_PHASE     = 8;    // from here on, no idling at all
   localparam int LONG_HOLD       = 300;
   localparam int TAIL_CYCLES     = 20;
   localparam int WATCHDOG_LIMIT  = 4000;

   // Spare codes: the unused mode and a register index past the list
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam logic [2:0] CSR_SPARE  = 3'd7;

   typedef struct packed {
      opcode_type         opcode;
      logic signed [15:0] level;
      logic signed [15:0] flow;
      logic [15:0]        opening;
      logic               upper_hit;
      logic               lower_hit;
   } tick_type;

   typedef struct packed {
      action_type         action;
      logic signed [16:0] speed;
      logic [15:0]        target;
      logic signed [16:0] err;
   } gate_cmd_type;

   logic clock = 1'b0;
   logic reset;

   logic               req_valid;
   logic               req_stall;
   logic               req_opcode;
   logic signed [15:0] req_measured_level;
   logic signed [15:0] req_measured_flow;
   logic [15:0]        req_gate_opening;
   logic               req_upper_limit_hit;
   logic               req_lower_limit_hit;

   logic               rsp_valid;
   logic               rsp_stall;
   action_type         rsp_action;
   logic signed [16:0] rsp_drive_speed;
   logic [15:0]        rsp_target_opening;
   logic signed [16:0] rsp_control_error;

   logic               csr_write;
   logic [2:0]         csr_index;
   logic [15:0]        csr_wdata;

   // Register mirror and integral, updated on the same edges as the block
   logic [1:0]         cfg_mode;
   logic signed [15:0] cfg_level_sp;
   logic signed [15:0] cfg_flow_sp;
   logic [15:0]        cfg_speed_lim;
   logic [15:0]        cfg_level_db;
   logic [15:0]        cfg_flow_db;
   longint             level_sum;

   tick_type     tick_backlog[$];   // ticks waiting to be driven
   gate_cmd_type awaited_cmds[$];   // predicted responses, oldest first

   bit req_fire;                 // request transfer at the last rising edge
   bit idle_on;                  // random gaps and stalls enabled
   bit long_hold_req;            // asks the receiver for one long hold-off
   int send_gap;
   int hold_left;
   int idle_cycles;
   int mismatch_count;

   gate_level_flow_pi_controller_unit #(
      .INTEGRAL_WIDTH(SUM_WIDTH)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_measured_level  (req_measured_level),
      .req_measured_flow   (req_measured_flow),
      .req_gate_opening    (req_gate_opening),
      .req_upper_limit_hit (req_upper_limit_hit),
      .req_lower_limit_hit (req_lower_limit_hit),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_action          (rsp_action),
      .rsp_drive_speed     (rsp_drive_speed),
      .rsp_target_opening  (rsp_target_opening),
      .rsp_control_error   (rsp_control_error),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Real output v is Q8.8; 1.0 and above pins to the top Q0.16 code
   function automatic logic [15:0] clamp_opening(longint v);
      if (v <= 0) return 16'd0;
      if (v >= 256) return 16'hffff;
      return 16'(v * 256);
   endfunction

   // Deadband first, then direction gated by the switch on that side
   function automatic action_type steer_gate(longint tgt, longint open_now, longint band,
                                             logic up_hit, logic dn_hit);
      longint d, mag;
      d   = tgt - open_now;
      mag = (d < 0) ? -d : d;
      if (mag < band) return ACT_STOP;
      if (d > 0 && !up_hit) return ACT_UP;
      if (d < 0 && !dn_hit) return ACT_DOWN;
      return ACT_HOLD;
   endfunction

   // One response per request; updates the integral as a side effect
   function automatic gate_cmd_type compute_gate_command(tick_type t);
      gate_cmd_type c;
      longint e, spd, mag, lim, v;
      c.action = ACT_HOLD;
      c.speed  = '0;
      c.target = '0;
      c.err    = '0;
      if (t.opcode == OP_CLEAR) begin
         level_sum = 0;
      end else if (cfg_mode == MODE_SPEED) begin
         e   = longint'(cfg_level_sp) - longint'(t.level);
         spd = (e * LEVEL_GAIN) >>> 8;   // floor of the Q8.8 product
         lim = longint'(cfg_speed_lim);
         if (spd > lim) spd = lim;
         if (spd < -lim) spd = -lim;
         mag = (spd < 0) ? -spd : spd;
         if (mag < STOP_SPEED) c.action = ACT_STOP;
         else if (spd > 0 && !t.upper_hit) c.action = ACT_RUN;
         else if (spd < 0 && !t.lower_hit) c.action = ACT_RUN;
         c.speed = 17'(spd);
         c.err   = 17'(e);
      end else if (cfg_mode == MODE_LEVEL) begin
         e = longint'(cfg_level_sp) - longint'(t.level);
         level_sum = level_sum + e;
         if (level_sum > SUM_MAX) level_sum = SUM_MAX;
         if (level_sum < SUM_MIN) level_sum = SUM_MIN;
         v = e * LEVEL_GAIN + level_sum * SUM_GAIN;
         c.target = clamp_opening(v);
         c.action = steer_gate(longint'(c.target), longint'(t.opening),
                               longint'(cfg_level_db), t.upper_hit, t.lower_hit);
         c.err    = 17'(e);
      end else if (cfg_mode == MODE_FLOW) begin
         e = longint'(cfg_flow_sp) - longint'(t.flow);
         c.target = clamp_opening(e * FLOW_GAIN);
         c.action = steer_gate(longint'(c.target), longint'(t.opening),
                               longint'(cfg_flow_db), t.upper_hit, t.lower_hit);
         c.err    = 17'(e);
      end
      // spare mode: hold with zero fields, integral untouched
      return c;
   endfunction

   // ------------------------------------------------------------------------
   // Monitor: mirrors register writes, predicts on request transfers and
   // checks response transfers. Samples at the rising edge only.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      tick_type     seen;
      gate_cmd_type want;
      if (reset) begin
         cfg_mode      = MODE_LEVEL;
         cfg_level_sp  = '0;
         cfg_flow_sp   = '0;
         cfg_speed_lim = SPEED_LIMIT_RESET;
         cfg_level_db  = DEADBAND_RESET;
         cfg_flow_db   = DEADBAND_RESET;
         level_sum     = 0;
         req_fire      = 1'b0;
         idle_cycles   = 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_MODE:           cfg_mode      = csr_wdata[1:0];
               CSR_LEVEL_SETPOINT: cfg_level_sp  = csr_wdata;
               CSR_FLOW_SETPOINT:  cfg_flow_sp   = csr_wdata;
               CSR_SPEED_LIMIT:    cfg_speed_lim = csr_wdata;
               CSR_LEVEL_DEADBAND: cfg_level_db  = csr_wdata;
               CSR_FLOW_DEADBAND:  cfg_flow_db   = csr_wdata;
               default: ;   // index past the list is ignored
            endcase
         end

         req_fire = req_valid && !req_stall;
         if (req_fire) begin
            seen.opcode    = opcode_type'(req_opcode);
            seen.level     = req_measured_level;
            seen.flow      = req_measured_flow;
            seen.opening   = req_gate_opening;
            seen.upper_hit = req_upper_limit_hit;
            seen.lower_hit = req_lower_limit_hit;
            awaited_cmds.push_back(compute_gate_command(seen));
         end

         if (rsp_valid && !rsp_stall) begin
            if (awaited_cmds.size() == 0) begin
               $error("response transfer with no request outstanding");
               mismatch_count++;
            end else begin
               want = awaited_cmds.pop_front();
               if (rsp_action !== want.action) begin
                  $error("action: expected %0d, actual %0d", want.action, rsp_action);
                  mismatch_count++;
               end
               if (rsp_drive_speed !== want.speed) begin
                  $error("drive_speed: expected %0d, actual %0d",
                         want.speed, rsp_drive_speed);
                  mismatch_count++;
               end
               if (rsp_target_opening !== want.target) begin
                  $error("target_opening: expected %0d, actual %0d",
                         want.target, rsp_target_opening);
                  mismatch_count++;
               end
               if (rsp_control_error !== want.err) begin
                  $error("control_error: expected %0d, actual %0d",
                         want.err, rsp_control_error);
                  mismatch_count++;
               end
            end
         end

         // Watchdog: too long without any transfer means the block is stuck
         if (req_fire || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("[FAIL] regression broken");
               $finish;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request driver: falling edge. A stalled request stays as it is; after a
   // transfer the next tick goes out, unless a random gap is running.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      tick_type t;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (send_gap != 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (tick_backlog.size() == 0) begin
            req_valid <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(0, 15);   // random gap before the next tick
            req_valid <= 1'b0;
         end else begin
            t = tick_backlog.pop_front();
            req_opcode          <= t.opcode;
            req_measured_level  <= t.level;
            req_measured_flow   <= t.flow;
            req_gate_opening    <= t.opening;
            req_upper_limit_hit <= t.upper_hit;
            req_lower_limit_hit <= t.lower_hit;
            req_valid           <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response stall: random bursts, plus one long hold-off on request so the
   // pipe fills and the block stalls its request side.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (long_hold_req) begin
         long_hold_req = 1'b0;
         hold_left = LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         hold_left = $urandom_range(0, 15);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------

   // Register write, one cycle wide, on the falling edge
   task automatic csr_put(logic [2:0] idx, logic [15:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic push_tick(opcode_type op, logic [15:0] level, logic [15:0] flow,
                            logic [15:0] opening, logic up_hit, logic dn_hit);
      tick_type t;
      t.opcode    = op;
      t.level     = level;
      t.flow      = flow;
      t.opening   = opening;
      t.upper_hit = up_hit;
      t.lower_hit = dn_hit;
      tick_backlog.push_back(t);
   endtask

   // Sender pause: nothing queued, nothing offered, every response back
   task automatic drain_pipe();
      do @(posedge clock);
      while (tick_backlog.size() != 0 || req_valid || awaited_cmds.size() != 0);
   endtask

   // Half the measurements sit near the setpoint, where the errors are small
   // and the deadband matters; openings cluster near targets.
   function automatic tick_type random_tick();
      tick_type t;
      int       base;
      t.opcode = ($urandom_range(0, 19) == 0) ? OP_CLEAR : OP_TICK;
      t.level  = $urandom_range(0, 1) ? 16'(cfg_level_sp + $urandom_range(0, 8) - 4)
                                      : 16'($urandom);
      t.flow   = $urandom_range(0, 1) ? 16'(cfg_flow_sp + $urandom_range(0, 8) - 4)
                                      : 16'($urandom);
      if ($urandom_range(0, 2) == 0) begin
         t.opening = 16'($urandom);
      end else begin
         base = ($urandom_range(0, 3) == 3) ? 65535 : $urandom_range(0, 2) * 25600;
         t.opening = 16'(base + $urandom_range(0, 1500) - 750);
      end
      t.upper_hit = ($urandom_range(0, 3) == 0);
      t.lower_hit = ($urandom_range(0, 3) == 0);
      return t;
   endfunction

   function automatic logic [15:0] pick_setpoint();
      case ($urandom_range(0, 7))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_band(int top);
      case ($urandom_range(0, 3))
         0:       return 16'd0;
         1:       return 16'hffff;
         2:       return 16'($urandom_range(0, top));
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int p, n;
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_opcode          = OP_TICK;
      req_measured_level  = '0;
      req_measured_flow   = '0;
      req_gate_opening    = '0;
      req_upper_limit_hit = 1'b0;
      req_lower_limit_hit = 1'b0;
      rsp_stall           = 1'b0;
      csr_write           = 1'b0;
      csr_index           = CSR_MODE;
      csr_wdata           = '0;
      idle_on             = 1'b1;
      long_hold_req       = 1'b0;
      send_gap            = 0;
      hold_left           = 0;
      mismatch_count      = 0;

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Level PI from reset defaults, top setpoint: the largest positive
      // error drives the integral into its upper rail; openings at both
      // ends, switches on and off. Then a zero error still pins the target
      // through the sum, and a clear brings it back to zero.
      csr_put(CSR_LEVEL_SETPOINT, 16'h7fff);
      for (n = 0; n < 9; n++)
         push_tick(OP_TICK, 16'h8000, 16'h0000, n[0] ? 16'hffff : 16'h0000,
                   n[1], n[2]);
      push_tick(OP_TICK, 16'h7fff, 16'h7fff, 16'h8000, 1'b0, 1'b0);
      push_tick(OP_CLEAR, 16'hffff, 16'hffff, 16'hffff, 1'b1, 1'b1);
      push_tick(OP_TICK, 16'h7fff, 16'h8000, 16'h0000, 1'b0, 1'b0);
      drain_pipe();

      // Bottom setpoint: integral into its lower rail
      csr_put(CSR_LEVEL_SETPOINT, 16'h8000);
      for (n = 0; n < 9; n++)
         push_tick(OP_TICK, 16'h7fff, 16'h0000, n[0] ? 16'h0000 : 16'h8000,
                   n[1], n[2]);
      drain_pipe();

      // Speed mode with a zero limit: everything clamps to stop
      csr_put(CSR_MODE, 16'(MODE_SPEED));
      csr_put(CSR_SPEED_LIMIT, 16'd0);
      push_tick(OP_TICK, 16'h7fff, 16'h0000, 16'h0000, 1'b0, 1'b0);
      drain_pipe();

      // Full limit: clamp both ways, switch blocking, floor rounding and
      // the stop threshold just below and above
      csr_put(CSR_SPEED_LIMIT, 16'hffff);
      csr_put(CSR_LEVEL_SETPOINT, 16'h0000);
      push_tick(OP_TICK, 16'h8000, 16'h0000, 16'h0000, 1'b1, 1'b0);
      push_tick(OP_TICK, 16'h7fff, 16'h0000, 16'h0000, 1'b0, 1'b0);
      push_tick(OP_TICK, 16'hffff, 16'h0000, 16'h0000, 1'b0, 1'b0);
      push_tick(OP_TICK, 16'h0001, 16'h0000, 16'h0000, 1'b0, 1'b0);
      push_tick(OP_TICK, 16'hfffe, 16'h0000, 16'h0000, 1'b0, 1'b0);
      drain_pipe();

      // Flow mode, zero deadband: exact match holds, top clamp blocked by
      // the upper switch, bottom clamp moves down
      csr_put(CSR_MODE, 16'(MODE_FLOW));
      csr_put(CSR_FLOW_SETPOINT, 16'h0000);
      csr_put(CSR_FLOW_DEADBAND, 16'd0);
      push_tick(OP_TICK, 16'h0000, 16'hffff, 16'd25600, 1'b0, 1'b0);
      push_tick(OP_TICK, 16'h0000, 16'h8000, 16'h0000, 1'b1, 1'b0);
      push_tick(OP_TICK, 16'h0000, 16'h7fff, 16'hffff, 1'b0, 1'b0);
      drain_pipe();

      // Spare mode answers hold; a write past the register list is ignored
      csr_put(CSR_MODE, 16'(MODE_SPARE));
      csr_put(CSR_LEVEL_DEADBAND, 16'hffff);
      csr_put(CSR_SPARE, 16'hffff);
      push_tick(OP_TICK, 16'h8000, 16'h8000, 16'h1234, 1'b1, 1'b1);
      drain_pipe();

      // Random phases, a fresh setting each, cycling through the modes.
      // One phase holds the receiver off for a long stretch; the last ones
      // run without any gaps or stalls.
      for (p = 0; p < RANDOM_PHASES; p++) begin
         if (p >= QUIET_PHASE) idle_on = 1'b0;
         csr_put(CSR_MODE, 16'(p % 3));
         csr_put(CSR_LEVEL_SETPOINT, pick_setpoint());
         csr_put(CSR_FLOW_SETPOINT, pick_setpoint());
         csr_put(CSR_SPEED_LIMIT, pick_band(2000));
         csr_put(CSR_LEVEL_DEADBAND, pick_band(3000));
         csr_put(CSR_FLOW_DEADBAND, pick_band(3000));
         for (n = 0; n < ITEMS_PER_PHASE; n++)
            tick_backlog.push_back(random_tick());
         if (p == HOLD_PHASE) begin
            @(posedge clock);
            long_hold_req = 1'b1;
         end
         drain_pipe();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (awaited_cmds.size() != 0) begin
         $error("%0d responses never arrived", awaited_cmds.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### sim.f
+incdir+sv
sv/glfpi_pkg.sv
sv/gate_level_flow_pi_controller_unit.sv
sv/glfpi_checker.sv
verif/gate_level_flow_pi_controller_unit_tb.sv
